[src/pau_pkg.sv]
// shared types, constants and helpers for the particle attractor update pipeline
// no dependencies
`default_nettype none

package pau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CFG_W     = 31;
  localparam int QUO_W     = 31;
  localparam int ROOT_W    = 32;
  localparam int UNIT_LAT  = 32;
  localparam int PIPE_LAT  = 9 + 4 * UNIT_LAT;

  localparam logic [CFG_W-1:0] MAX_SPEED_RST   = 31'd131072;
  localparam logic [CFG_W-1:0] GRAVITY_RST     = 31'd65536;
  localparam logic [CFG_W-1:0] DIST_SQ_MIN_RST = 31'd327680;
  localparam logic [CFG_W-1:0] DIST_SQ_MAX_RST = 31'd3276800;
  localparam logic [QUO_W-1:0] Q_MAX           = '1;

  typedef enum logic [1:0] {
    CFG_MAX_SPEED   = 2'd0,
    CFG_GRAVITY     = 2'd1,
    CFG_DIST_SQ_MIN = 2'd2,
    CFG_DIST_SQ_MAX = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] attractor_x;
    logic signed [31:0] attractor_y;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_acc_x;
    logic signed [31:0] new_acc_y;
  } out_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -34'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] u;
    u = v;
    return v[31] ? (~u + 32'd1) : u;
  endfunction

endpackage

`default_nettype wire

[src/pau_div.sv]
// pipelined restoring divider, one quotient bit per stage, saturating quotient
// depends on pau_pkg
`default_nettype none

module pau_div
  import pau_pkg::*;
(
  input  logic             clk,
  input  logic [62:0]      num,
  input  logic [31:0]      den,
  output logic [QUO_W-1:0] quo
);

  logic [62:0]      rem_r [QUO_W];
  logic [31:0]      den_r [QUO_W];
  logic [QUO_W-1:0] q_r   [QUO_W+1];
  logic             sat_r [QUO_W+1];

  // overflow or divide by zero
  always_ff @(posedge clk) begin
    rem_r[0] <= num;
    den_r[0] <= den;
    q_r[0]   <= '0;
    sat_r[0] <= (den == '0) || (num[62:QUO_W] >= den);
  end

  for (genvar s = 1; s <= QUO_W; s++) begin : g_stage
    localparam int K = QUO_W - s;
    logic [62:0]      trial;
    logic             ge;
    logic [QUO_W-1:0] q_nxt;

    assign trial = 63'(den_r[s-1]) << K;
    assign ge    = rem_r[s-1] >= trial;

    always_comb begin
      q_nxt    = q_r[s-1];
      q_nxt[K] = ge;
    end

    always_ff @(posedge clk) begin
      q_r[s]   <= q_nxt;
      sat_r[s] <= sat_r[s-1];
    end

    if (s < QUO_W) begin : g_fwd
      always_ff @(posedge clk) begin
        rem_r[s] <= ge ? (rem_r[s-1] - trial) : rem_r[s-1];
        den_r[s] <= den_r[s-1];
      end
    end
  end

  assign quo = sat_r[QUO_W] ? Q_MAX : q_r[QUO_W];

endmodule

`default_nettype wire

[src/pau_sqrt.sv]
// pipelined integer square root of a 64-bit value, one root bit per stage
// no dependencies
`default_nettype none

module pau_sqrt (
  input  logic        clk,
  input  logic [63:0] rad,
  output logic [31:0] root
);

  logic [63:0] rem_r  [32];
  logic [31:0] root_r [32];

  for (genvar s = 0; s < 32; s++) begin : g_stage
    localparam int K = 31 - s;
    logic [63:0] rem_in;
    logic [31:0] root_in;
    logic [65:0] trial;
    logic [65:0] diff;
    logic        ge;
    logic [31:0] root_nxt;

    if (s == 0) begin : g_first
      assign rem_in  = rad;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
    end

    assign trial = (66'(root_in) << (K + 1)) | (66'd1 << (2 * K));
    assign ge    = {2'b00, rem_in} >= trial;
    assign diff  = {2'b00, rem_in} - trial;

    always_comb begin
      root_nxt    = root_in;
      root_nxt[K] = ge;
    end

    always_ff @(posedge clk) begin
      root_r[s] <= root_nxt;
      rem_r[s]  <= ge ? diff[63:0] : rem_in;
    end
  end

  assign root = root_r[31];

endmodule

`default_nettype wire

[src/particle_attractor_update.sv]
// top level of the particle attractor update pipeline
// depends on pau_pkg, pau_div, pau_sqrt
`default_nettype none

// One particle enters per cycle whenever start is high; busy stays low. Each
// result appears on out_data for one cycle with out_valid, in request order.
// Each request passes through four 32-stage units in a row: force divider
// with distance square root, direction dividers, length-cap square roots, and
// length-cap dividers. The receiver cannot stall. Configuration writes are
// always accepted and must only be made while no request is in flight.

module particle_attractor_update
  import pau_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_t              in_data,
  output logic             out_valid,
  output out_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic               rsx;
    logic               rsy;
    logic               rnz;
    logic               ova;
    logic               ovv;
    logic [30:0]        hx;
    logic [30:0]        hy;
  } pay_t;

  localparam int DW = 65 - FRAC_BITS;

  logic [CFG_W-1:0] max_speed_r, gravity_r, dsq_min_r, dsq_max_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r <= MAX_SPEED_RST;
      gravity_r   <= GRAVITY_RST;
      dsq_min_r   <= DIST_SQ_MIN_RST;
      dsq_max_r   <= DIST_SQ_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MAX_SPEED:   max_speed_r <= cfg_data;
        CFG_GRAVITY:     gravity_r   <= cfg_data;
        CFG_DIST_SQ_MIN: dsq_min_r   <= cfg_data;
        CFG_DIST_SQ_MAX: dsq_max_r   <= cfg_data;
        default:         max_speed_r <= max_speed_r;
      endcase
    end
  end

  // stage 1: r, magnitudes, halving
  logic signed [32:0] rx, ry;
  logic [32:0]        nrx, nry;
  logic [31:0]        ux, uy;
  logic               halve;
  pay_t               pay_c1;

  always_comb begin
    rx     = {in_data.attractor_x[31], in_data.attractor_x} - {in_data.pos_x[31], in_data.pos_x};
    ry     = {in_data.attractor_y[31], in_data.attractor_y} - {in_data.pos_y[31], in_data.pos_y};
    nrx    = ~rx + 33'd1;
    nry    = ~ry + 33'd1;
    ux     = rx[32] ? nrx[31:0] : rx[31:0];
    uy     = ry[32] ? nry[31:0] : ry[31:0];
    halve  = ux[31] | uy[31];
    pay_c1 = '0;
    pay_c1.px  = in_data.pos_x;
    pay_c1.py  = in_data.pos_y;
    pay_c1.vx  = in_data.vel_x;
    pay_c1.vy  = in_data.vel_y;
    pay_c1.cx  = in_data.acc_x;
    pay_c1.cy  = in_data.acc_y;
    pay_c1.rsx = rx[32];
    pay_c1.rsy = ry[32];
    pay_c1.rnz = (rx != '0) || (ry != '0);
    pay_c1.hx  = halve ? ux[31:1] : ux[30:0];
    pay_c1.hy  = halve ? uy[31:1] : uy[30:0];
  end

  logic        v1_r;
  pay_t        pay1_r;
  logic [31:0] ux1_r, uy1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    pay1_r <= pay_c1;
    ux1_r  <= ux;
    uy1_r  <= uy;
  end

  // stage 2: squares
  logic        v2_r;
  pay_t        pay2_r;
  logic [63:0] sqx2_r, sqy2_r;
  logic [61:0] hsqx2_r, hsqy2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    pay2_r  <= pay1_r;
    sqx2_r  <= 64'(ux1_r) * 64'(ux1_r);
    sqy2_r  <= 64'(uy1_r) * 64'(uy1_r);
    hsqx2_r <= 62'(pay1_r.hx) * 62'(pay1_r.hx);
    hsqy2_r <= 62'(pay1_r.hy) * 62'(pay1_r.hy);
  end

  // stage 3: squared distance and clamp
  logic [64:0]      dsum;
  logic [DW-1:0]    d_full;
  logic [CFG_W-1:0] d_hi, d_cl;
  logic [62:0]      hsum;

  always_comb begin
    dsum   = {1'b0, sqx2_r} + {1'b0, sqy2_r};
    d_full = dsum[64:FRAC_BITS];
    d_hi   = (d_full > DW'(dsq_max_r)) ? dsq_max_r : d_full[CFG_W-1:0];
    d_cl   = (d_hi < dsq_min_r) ? dsq_min_r : d_hi;
    hsum   = {1'b0, hsqx2_r} + {1'b0, hsqy2_r};
  end

  logic             v3_r;
  pay_t             pay3_r;
  logic [CFG_W-1:0] d3_r;
  logic [62:0]      hsum3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    pay3_r  <= pay2_r;
    d3_r    <= d_cl;
    hsum3_r <= hsum;
  end

  // force size and length of r
  logic [QUO_W-1:0] f_q;
  logic [31:0]      nr_q;

  pau_div u_div_force (
    .clk (clk),
    .num (63'(gravity_r) << FRAC_BITS),
    .den (32'(d3_r)),
    .quo (f_q)
  );

  pau_sqrt u_sqrt_r (
    .clk  (clk),
    .rad  (64'(hsum3_r)),
    .root (nr_q)
  );

  logic [UNIT_LAT-1:0] va_r;
  pay_t                pa_r [UNIT_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= '0;
    end else begin
      va_r <= {va_r[UNIT_LAT-2:0], v3_r};
    end
  end

  always_ff @(posedge clk) begin
    pa_r[0] <= pay3_r;
    for (int i = 1; i < UNIT_LAT; i++) begin
      pa_r[i] <= pa_r[i-1];
    end
  end

  // stage 4: component numerators
  logic        v4_r;
  pay_t        pay4_r;
  logic [62:0] mnx4_r, mny4_r;
  logic [31:0] n4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= va_r[UNIT_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    pay4_r <= pa_r[UNIT_LAT-1];
    mnx4_r <= 63'(pa_r[UNIT_LAT-1].hx) * 63'(f_q);
    mny4_r <= 63'(pa_r[UNIT_LAT-1].hy) * 63'(f_q);
    n4_r   <= nr_q;
  end

  logic [QUO_W-1:0] mx_q, my_q;

  pau_div u_div_fx (
    .clk (clk),
    .num (mnx4_r),
    .den (n4_r),
    .quo (mx_q)
  );

  pau_div u_div_fy (
    .clk (clk),
    .num (mny4_r),
    .den (n4_r),
    .quo (my_q)
  );

  logic [UNIT_LAT-1:0] vb_r;
  pay_t                pb_r [UNIT_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= '0;
    end else begin
      vb_r <= {vb_r[UNIT_LAT-2:0], v4_r};
    end
  end

  always_ff @(posedge clk) begin
    pb_r[0] <= pay4_r;
    for (int i = 1; i < UNIT_LAT; i++) begin
      pb_r[i] <= pb_r[i-1];
    end
  end

  // stage 5: add force, add acceleration to velocity
  pay_t               pb_o, pay_c5;
  logic signed [32:0] smx, smy;
  logic signed [31:0] cxn, cyn;

  always_comb begin
    pb_o   = pb_r[UNIT_LAT-1];
    smx    = pb_o.rsx ? -$signed({2'b00, mx_q}) : $signed({2'b00, mx_q});
    smy    = pb_o.rsy ? -$signed({2'b00, my_q}) : $signed({2'b00, my_q});
    cxn    = pb_o.rnz ? sat32({{2{pb_o.cx[31]}}, pb_o.cx} + {smx[32], smx}) : pb_o.cx;
    cyn    = pb_o.rnz ? sat32({{2{pb_o.cy[31]}}, pb_o.cy} + {smy[32], smy}) : pb_o.cy;
    pay_c5    = pb_o;
    pay_c5.cx = cxn;
    pay_c5.cy = cyn;
    pay_c5.vx = sat32({{2{pb_o.vx[31]}}, pb_o.vx} + {{2{cxn[31]}}, cxn});
    pay_c5.vy = sat32({{2{pb_o.vy[31]}}, pb_o.vy} + {{2{cyn[31]}}, cyn});
  end

  logic v5_r;
  pay_t pay5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= vb_r[UNIT_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    pay5_r <= pay_c5;
  end

  // stage 6: squared lengths
  logic        v6_r;
  pay_t        pay6_r;
  logic [63:0] sqcx6_r, sqcy6_r, sqvx6_r, sqvy6_r;
  logic [61:0] lsq6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    pay6_r  <= pay5_r;
    sqcx6_r <= 64'(mag32(pay5_r.cx)) * 64'(mag32(pay5_r.cx));
    sqcy6_r <= 64'(mag32(pay5_r.cy)) * 64'(mag32(pay5_r.cy));
    sqvx6_r <= 64'(mag32(pay5_r.vx)) * 64'(mag32(pay5_r.vx));
    sqvy6_r <= 64'(mag32(pay5_r.vy)) * 64'(mag32(pay5_r.vy));
    lsq6_r  <= 62'(max_speed_r) * 62'(max_speed_r);
  end

  // stage 7: compare with the cap
  logic [63:0] sqa, sqv;
  pay_t        pay_c7;

  always_comb begin
    sqa        = sqcx6_r + sqcy6_r;
    sqv        = sqvx6_r + sqvy6_r;
    pay_c7     = pay6_r;
    pay_c7.ova = sqa > 64'(lsq6_r);
    pay_c7.ovv = sqv > 64'(lsq6_r);
  end

  logic        v7_r;
  pay_t        pay7_r;
  logic [63:0] sqa7_r, sqv7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    pay7_r <= pay_c7;
    sqa7_r <= sqa;
    sqv7_r <= sqv;
  end

  logic [31:0] na_q, nv_q;

  pau_sqrt u_sqrt_acc (
    .clk  (clk),
    .rad  (sqa7_r),
    .root (na_q)
  );

  pau_sqrt u_sqrt_vel (
    .clk  (clk),
    .rad  (sqv7_r),
    .root (nv_q)
  );

  logic [UNIT_LAT-1:0] vc_r;
  pay_t                pc_r [UNIT_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= '0;
    end else begin
      vc_r <= {vc_r[UNIT_LAT-2:0], v7_r};
    end
  end

  always_ff @(posedge clk) begin
    pc_r[0] <= pay7_r;
    for (int i = 1; i < UNIT_LAT; i++) begin
      pc_r[i] <= pc_r[i-1];
    end
  end

  // stage 8: cap numerators
  logic        v8_r;
  pay_t        pay8_r;
  logic [62:0] pcx8_r, pcy8_r, pvx8_r, pvy8_r;
  logic [31:0] na8_r, nv8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else begin
      v8_r <= vc_r[UNIT_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    pay8_r <= pc_r[UNIT_LAT-1];
    pcx8_r <= 63'(mag32(pc_r[UNIT_LAT-1].cx)) * 63'(max_speed_r);
    pcy8_r <= 63'(mag32(pc_r[UNIT_LAT-1].cy)) * 63'(max_speed_r);
    pvx8_r <= 63'(mag32(pc_r[UNIT_LAT-1].vx)) * 63'(max_speed_r);
    pvy8_r <= 63'(mag32(pc_r[UNIT_LAT-1].vy)) * 63'(max_speed_r);
    na8_r  <= na_q;
    nv8_r  <= nv_q;
  end

  logic [QUO_W-1:0] qcx, qcy, qvx, qvy;

  pau_div u_div_cx (.clk(clk), .num(pcx8_r), .den(na8_r), .quo(qcx));
  pau_div u_div_cy (.clk(clk), .num(pcy8_r), .den(na8_r), .quo(qcy));
  pau_div u_div_vx (.clk(clk), .num(pvx8_r), .den(nv8_r), .quo(qvx));
  pau_div u_div_vy (.clk(clk), .num(pvy8_r), .den(nv8_r), .quo(qvy));

  logic [UNIT_LAT-1:0] vd_r;
  pay_t                pd_r [UNIT_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= '0;
    end else begin
      vd_r <= {vd_r[UNIT_LAT-2:0], v8_r};
    end
  end

  always_ff @(posedge clk) begin
    pd_r[0] <= pay8_r;
    for (int i = 1; i < UNIT_LAT; i++) begin
      pd_r[i] <= pd_r[i-1];
    end
  end

  // stage 9: apply cap, move position
  pay_t               pd_o;
  logic signed [31:0] cfx, cfy, vfx, vfy;
  out_t               out_c;

  always_comb begin
    pd_o = pd_r[UNIT_LAT-1];
    cfx  = pd_o.ova ? (pd_o.cx[31] ? -$signed({1'b0, qcx}) : $signed({1'b0, qcx})) : pd_o.cx;
    cfy  = pd_o.ova ? (pd_o.cy[31] ? -$signed({1'b0, qcy}) : $signed({1'b0, qcy})) : pd_o.cy;
    vfx  = pd_o.ovv ? (pd_o.vx[31] ? -$signed({1'b0, qvx}) : $signed({1'b0, qvx})) : pd_o.vx;
    vfy  = pd_o.ovv ? (pd_o.vy[31] ? -$signed({1'b0, qvy}) : $signed({1'b0, qvy})) : pd_o.vy;
    out_c.new_pos_x = sat32({{2{pd_o.px[31]}}, pd_o.px} + {{2{vfx[31]}}, vfx});
    out_c.new_pos_y = sat32({{2{pd_o.py[31]}}, pd_o.py} + {{2{vfy[31]}}, vfy});
    out_c.new_vel_x = vfx;
    out_c.new_vel_y = vfy;
    out_c.new_acc_x = cfx;
    out_c.new_acc_y = cfy;
  end

  logic v9_r;
  out_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else begin
      v9_r <= vd_r[UNIT_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_c;
  end

  assign out_valid = v9_r;
  assign out_data  = out_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result without a matching request");

  a_acc_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (mag32(out_data.new_acc_x) <= 32'(max_speed_r)) &&
                  (mag32(out_data.new_acc_y) <= 32'(max_speed_r)))
    else $error("acceleration exceeds cap");

  a_vel_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (mag32(out_data.new_vel_x) <= 32'(max_speed_r)) &&
                  (mag32(out_data.new_vel_y) <= 32'(max_speed_r)))
    else $error("velocity exceeds cap");

endmodule

`default_nettype wire

[sim/tb_top.sv]
// self-checking testbench for particle_attractor_update: directed table, then random particles
// over several register settings, each result checked against a typed expected result or
// a bit-exact Q16.16 predictor; depends on pau_pkg and the particle_attractor_update rtl
`default_nettype none

module tb_top;
  import pau_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 4000;
  localparam int RAND_PER_PHASE = 130;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t result;
  } row_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_t              in_data;
  logic             out_valid;
  out_t             out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  longint unsigned speed_cap, grav, dmin, dmax;
  out_t expected_q[$];
  int   errors = 0;
  int   idle_cycles = 0;
  row_t dir_rows[$];

  particle_attractor_update u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? 64'd0 - longint'(v) : longint'(v);
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint scale_signed(longint c, longint unsigned mc,
                                          longint unsigned num, longint unsigned den);
    longint unsigned m;
    m = mc * num / den;
    return c < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic void cap_vector(inout longint x, inout longint y,
                                     input longint unsigned lim);
    longint unsigned ux, uy, sq, n;
    ux = magnitude(x);
    uy = magnitude(y);
    sq = ux * ux + uy * uy;
    if (sq <= lim * lim) return;
    n = int_sqrt(sq);
    x = scale_signed(x, ux, lim, n);
    y = scale_signed(y, uy, lim, n);
  endfunction

  function automatic out_t predict_update(in_t it);
    longint rx, ry, px, py, vx, vy, cx, cy;
    longint unsigned ux, uy, sqx, sqy, d, f, n, fm;
    out_t res;
    px = longint'(it.pos_x);
    py = longint'(it.pos_y);
    vx = longint'(it.vel_x);
    vy = longint'(it.vel_y);
    cx = longint'(it.acc_x);
    cy = longint'(it.acc_y);
    rx = longint'(it.attractor_x) - px;
    ry = longint'(it.attractor_y) - py;
    if (rx != 0 || ry != 0) begin
      fm = (64'd1 << FRAC_BITS) - 1;
      ux = magnitude(rx);
      uy = magnitude(ry);
      sqx = ux * ux;
      sqy = uy * uy;
      d = (sqx >> FRAC_BITS) + (sqy >> FRAC_BITS) + (((sqx & fm) + (sqy & fm)) >> FRAC_BITS);
      if (d > dmax) d = dmax;
      if (d < dmin) d = dmin;
      if (d == 0) f = 64'd2147483647;
      else f = (grav << FRAC_BITS) / d;
      if (f > 64'd2147483647) f = 64'd2147483647;
      if (ux >= 64'h80000000 || uy >= 64'h80000000) begin
        ux >>= 1;
        uy >>= 1;
      end
      n = int_sqrt(ux * ux + uy * uy);
      cx = clip32(cx + scale_signed(rx, ux, f, n));
      cy = clip32(cy + scale_signed(ry, uy, f, n));
    end
    vx = clip32(vx + cx);
    vy = clip32(vy + cy);
    cap_vector(cx, cy, speed_cap);
    cap_vector(vx, vy, speed_cap);
    px = clip32(px + vx);
    py = clip32(py + vy);
    res.new_pos_x = px[31:0];
    res.new_pos_y = py[31:0];
    res.new_vel_x = vx[31:0];
    res.new_vel_y = vy[31:0];
    res.new_acc_x = cx[31:0];
    res.new_acc_y = cy[31:0];
    return res;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
      default: return 32'($urandom_range(0, 32'h0000_8000)) - 32'h0000_4000;
    endcase
  endfunction

  function automatic in_t rand_particle();
    in_t it;
    it.pos_x = rand_coord();
    it.pos_y = rand_coord();
    if ($urandom_range(0, 3) == 0) begin
      it.attractor_x = rand_coord();
      it.attractor_y = rand_coord();
    end else begin
      it.attractor_x = it.pos_x + 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
      it.attractor_y = it.pos_y + 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    end
    it.vel_x = rand_coord();
    it.vel_y = rand_coord();
    it.acc_x = rand_coord();
    it.acc_y = rand_coord();
    return it;
  endfunction

  task automatic send_particle(input in_t it, input bit typed, input out_t typed_res);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_data = it;
    do @(posedge clk); while (busy);
    expected_q = {expected_q, (typed ? typed_res : predict_update(it))};
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MAX_SPEED:   speed_cap = val;
      CFG_GRAVITY:     grav = val;
      CFG_DIST_SQ_MIN: dmin = val;
      CFG_DIST_SQ_MAX: dmax = val;
      default:         ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_regs(input logic [CFG_W-1:0] ms, input logic [CFG_W-1:0] g,
                          input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
    while (expected_q.size() != 0) @(negedge clk);
    write_reg(CFG_MAX_SPEED, ms);
    write_reg(CFG_GRAVITY, g);
    write_reg(CFG_DIST_SQ_MIN, lo);
    write_reg(CFG_DIST_SQ_MAX, hi);
  endtask

  task automatic random_burst(input int count);
    out_t none;
    none = '0;
    repeat (count) send_particle(rand_particle(), 1'b0, none);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h actual %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = expected_q.pop_front();
        check_field("new_pos_x", e.new_pos_x, out_data.new_pos_x);
        check_field("new_pos_y", e.new_pos_y, out_data.new_pos_y);
        check_field("new_vel_x", e.new_vel_x, out_data.new_vel_x);
        check_field("new_vel_y", e.new_vel_y, out_data.new_vel_y);
        check_field("new_acc_x", e.new_acc_x, out_data.new_acc_x);
        check_field("new_acc_y", e.new_acc_y, out_data.new_acc_y);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic row_t mk_row(input logic [31:0] ax, input logic [31:0] ay,
                                  input logic [31:0] px, input logic [31:0] py,
                                  input logic [31:0] vx, input logic [31:0] vy,
                                  input logic [31:0] cx, input logic [31:0] cy);
    row_t r;
    r.item = '{ax, ay, px, py, vx, vy, cx, cy};
    r.typed = 1'b0;
    r.result = '0;
    return r;
  endfunction

  initial begin
    row_t r;
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MAX_SPEED;
    cfg_data = '0;
    speed_cap = MAX_SPEED_RST;
    grav = GRAVITY_RST;
    dmin = DIST_SQ_MIN_RST;
    dmax = DIST_SQ_MAX_RST;

    // zero r, everything at rest
    r = mk_row(0, 0, 0, 0, 0, 0, 0, 0);
    r.typed = 1'b1;
    dir_rows = {dir_rows, r};
    dir_rows = {dir_rows, mk_row(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                                 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk_row(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                                 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000)};
    dir_rows = {dir_rows, mk_row(32'h00010000, 0, 0, 0, 32'h7fffffff, 32'h7fffffff,
                                 32'h7fffffff, 32'h7fffffff)};
    dir_rows = {dir_rows, mk_row(0, 32'hffff0000, 0, 0, 32'h80000000, 32'h80000000,
                                 32'h80000000, 32'h80000000)};
    dir_rows = {dir_rows, mk_row(32'h00030000, 32'h00040000, 32'h00010000, 32'hfffe0000,
                                 32'h00008000, 32'hffff8000, 32'h00001000, 0)};
    dir_rows = {dir_rows, mk_row(32'h7fff0000, 0, 32'h7fffffff, 32'h7fffffff,
                                 32'h00018000, 32'h00018000, 0, 0)};
    dir_rows = {dir_rows, mk_row(1, 1, 0, 0, 32'hffffffff, 1, 32'hffffffff, 1)};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) send_particle(dir_rows[i].item, dir_rows[i].typed,
                                        dir_rows[i].result);
    random_burst(RAND_PER_PHASE);

    // zero speed cap: position unchanged, velocity and acceleration zeroed
    set_regs('0, GRAVITY_RST, DIST_SQ_MIN_RST, DIST_SQ_MAX_RST);
    r = mk_row(32'h00100000, 32'h00200000, 5, 32'hfffffff9, 32'h00050000, 32'h00010000,
               32'h00020000, 32'hfffd0000);
    r.typed = 1'b1;
    r.result = '{32'sd5, -32'sd7, 0, 0, 0, 0};
    send_particle(r.item, r.typed, r.result);
    random_burst(RAND_PER_PHASE);

    // clamped distance zero saturates the force size
    set_regs('1, '1, '0, '0);
    foreach (dir_rows[i]) send_particle(dir_rows[i].item, 1'b0, dir_rows[i].result);
    random_burst(RAND_PER_PHASE);

    // zero and then nonzero gravity, minimum above maximum
    set_regs(MAX_SPEED_RST, '0, 31'd1000000, 31'd10);
    random_burst(RAND_PER_PHASE / 2);
    set_regs(31'd65536, 31'd300000, 31'd1000000, 31'd10);
    random_burst(RAND_PER_PHASE / 2);

    set_regs(31'($urandom()), 31'($urandom()), 31'($urandom_range(0, 32'h000f_ffff)),
             31'($urandom()));
    random_burst(RAND_PER_PHASE);

    while (expected_q.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
src/pau_pkg.sv
src/pau_div.sv
src/pau_sqrt.sv
src/particle_attractor_update.sv
sim/tb_top.sv
